>>> src/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg - shared types and constants of the Horner polynomial evaluator
// Fixed-point widths, register indexes, reset values and the word that
// travels from cell to cell.
// ----------------------------------------------------------------------------
package hpe_pkg;

  // Field widths
  localparam int COEF_W    = 32;               // Q15.16 coefficient and accumulator
  localparam int X_W       = 16;               // Q7.8 sample
  localparam int CNT_W     = 3;                // term count register
  localparam int PROD_W    = COEF_W + X_W;     // exact product, Q.24
  localparam int SUM_W     = COEF_W + 10;      // rounded product plus coefficient
  localparam int Q_SHIFT   = 8;
  localparam int NUM_COEFS = 6;
  localparam int IDX_W     = 3;

  // Rounding offset, half of the lowest bit kept after the shift
  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

  // Saturation limits, in the width of the unsaturated sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(32'sh8000_0000);

  // Register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_TERM_COUNT = 3'd0,
    REG_COEF_0     = 3'd1,
    REG_COEF_1     = 3'd2,
    REG_COEF_2     = 3'd3,
    REG_COEF_3     = 3'd4,
    REG_COEF_4     = 3'd5,
    REG_COEF_5     = 3'd6
  } hpe_reg_t;

  // Reset values
  localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 3'd6;
  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
    32'sh0003_0000, 32'sh0002_0000, 32'shFFFB_0000,
    32'shFFFF_0000, 32'sh0007_0000, 32'shFFFA_0000
  };

  // Word handed from one cell to the next
  typedef struct packed {
    logic signed [COEF_W-1:0] acc;
    logic signed [X_W-1:0]    x;
    logic                     ovf;
  } hpe_word_t;

endpackage

>>> src/hpe_cell.sv
// ----------------------------------------------------------------------------
// hpe_cell - one Horner step
// Stage A forms the exact product acc * x; stage B rounds half up, shifts
// back to Q15.16, adds the coefficient and saturates. An inactive cell
// hands its word on unchanged.
// ----------------------------------------------------------------------------
module hpe_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  hpe_pkg::hpe_word_t              up_word,
  input  logic signed [hpe_pkg::COEF_W-1:0] coef,
  input  logic                            active,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output hpe_pkg::hpe_word_t              dn_word
);
  import hpe_pkg::*;

  logic                     a_valid_r;
  hpe_word_t                a_word_r;
  logic signed [PROD_W-1:0] a_prod_r;
  logic                     a_ready;

  logic                     b_valid_r;
  hpe_word_t                b_word_r;
  hpe_word_t                b_word_nxt;
  logic                     b_ready;

  logic signed [PROD_W:0]   rnd_w;
  logic signed [SUM_W-1:0]  sum_w;

  // Each stage takes a word when it is empty or its word moves on
  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  // Stage A: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_word_r <= up_word;
      a_prod_r <= up_word.acc * up_word.x;
    end
  end

  // Stage B: round, shift, add coefficient, saturate
  assign rnd_w = (PROD_W + 1)'(a_prod_r) + ROUND_HALF;
  assign sum_w = SUM_W'(rnd_w >>> Q_SHIFT) + SUM_W'(coef);

  always_comb begin
    b_word_nxt = a_word_r;
    if (active) begin
      priority if (sum_w > SUM_MAX) begin
        b_word_nxt.acc = COEF_W'(SUM_MAX);
        b_word_nxt.ovf = 1'b1;
      end else if (sum_w < SUM_MIN) begin
        b_word_nxt.acc = COEF_W'(SUM_MIN);
        b_word_nxt.ovf = 1'b1;
      end else begin
        b_word_nxt.acc = COEF_W'(sum_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_word  = b_word_r;

endmodule

>>> src/horner_polynomial_eval_core.sv
// ----------------------------------------------------------------------------
// horner_polynomial_eval_core - streaming Horner polynomial evaluator
// Evaluates a polynomial of up to MAX_TERMS coefficients at each Q7.8 sample.
// ----------------------------------------------------------------------------
// A new sample is taken every clock cycle while the row is not stalled, and
// each result passes through every register of the row, whatever the term count:
// the row holds MAX_TERMS-1 identical cells, each a multiply stage and a
// round/add/saturate stage, followed by an output register, so a sustained
// rate of one word per cycle is set by that pipeline and back-pressure on the
// output stalls only as far up the row as words are queued. Coefficients are
// Q15.16, written leading first; cells past the term count pass the word on.
// Write configuration only while no words are in flight.
module horner_polynomial_eval_core #(
  parameter int MAX_TERMS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hpe_pkg::X_W-1:0]    in_sample_x,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hpe_pkg::COEF_W-1:0] out_poly_value,
  output logic                              out_overflow,
  input  logic                              cfg_we,
  input  logic [hpe_pkg::IDX_W-1:0]         cfg_index,
  input  logic [hpe_pkg::COEF_W-1:0]        cfg_wdata
);
  import hpe_pkg::*;

  localparam int NUM_CELLS = MAX_TERMS - 1;

  logic [CNT_W-1:0]          term_count_r;
  logic signed [COEF_W-1:0]  coef_r [NUM_COEFS];
  logic [CNT_W-1:0]          n_eff;

  logic                      chain_valid [NUM_CELLS+1];
  logic                      chain_ready [NUM_CELLS+1];
  hpe_word_t                 chain_word  [NUM_CELLS+1];

  logic                      out_valid_r;
  hpe_word_t                 out_word_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RESET;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= COEF_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_TERM_COUNT) begin
        term_count_r <= cfg_wdata[CNT_W-1:0];
      end
      for (int i = 0; i < NUM_COEFS; i++) begin
        if (cfg_index == IDX_W'(REG_COEF_0) + IDX_W'(i)) begin
          coef_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Clamp the term count to one .. MAX_TERMS
  always_comb begin
    priority if (term_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (term_count_r > CNT_W'(MAX_TERMS)) begin
      n_eff = CNT_W'(MAX_TERMS);
    end else begin
      n_eff = term_count_r;
    end
  end

  // Head of the row: accumulator starts at the leading coefficient
  assign chain_valid[0]     = in_valid;
  assign in_ready           = chain_ready[0];
  assign chain_word[0].acc  = coef_r[0];
  assign chain_word[0].x    = in_sample_x;
  assign chain_word[0].ovf  = 1'b0;

  // Row of Horner cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hpe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_word  (chain_word[k]),
      .coef     (coef_r[k+1]),
      .active   (CNT_W'(k + 1) < n_eff),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_word  (chain_word[k+1])
    );
  end

  // Output register
  assign chain_ready[NUM_CELLS] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chain_ready[NUM_CELLS]) begin
      out_valid_r <= chain_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[NUM_CELLS] && chain_valid[NUM_CELLS]) begin
      out_word_r <= chain_word[NUM_CELLS];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_value = out_word_r.acc;
  assign out_overflow   = out_word_r.ovf;

endmodule

>>> src/hpe_checker.sv
// ----------------------------------------------------------------------------
// hpe_checker - port-level checks of the Horner polynomial evaluator
// Watches the result channel and the back-pressure path.
// ----------------------------------------------------------------------------
module hpe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hpe_pkg::COEF_W-1:0] out_poly_value,
  input logic                              out_overflow
);
  import hpe_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_poly_value) && $stable(out_overflow))
    else $error("result word changed while stalled");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // An empty output means the whole row can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind horner_polynomial_eval_core hpe_checker u_hpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_poly_value (out_poly_value),
  .out_overflow   (out_overflow)
);
